>>> design/tnk_pkg.sv
`timescale 1ns / 1ps

package tnk_pkg;

   localparam int KEY_BITS        = 40;
   localparam int COUNT_BITS      = 4;
   localparam int MAX_ENTRIES_DEF = 8;
   localparam int TAG_BITS_DEF    = 16;

   localparam logic [COUNT_BITS-1:0] TARGET_N_RESET = COUNT_BITS'(8);

   localparam logic FUNC_OFFER = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_TOO_OLD   = 3'd2,
      ST_IGNORED   = 3'd3,
      ST_ENTRY     = 3'd4
   } status_type;

endpackage

>>> design/tnk_req_if.sv
`timescale 1ns / 1ps

interface tnk_req_if
   import tnk_pkg::*;
#(
   parameter int TAG_BITS = TAG_BITS_DEF
) ();
   logic                valid;
   logic                ready;
   logic                func;
   logic [KEY_BITS-1:0] key;
   logic [TAG_BITS-1:0] tag;

   modport source (output valid, output func, output key, output tag, input ready);
   modport sink   (input valid, input func, input key, input tag, output ready);
endinterface

>>> design/tnk_rsp_if.sv
`timescale 1ns / 1ps

interface tnk_rsp_if
   import tnk_pkg::*;
#(
   parameter int TAG_BITS = TAG_BITS_DEF
) ();
   logic                  valid;
   logic                  ready;
   status_type            status;
   logic                  entry_valid;
   logic [KEY_BITS-1:0]   entry_key;
   logic [TAG_BITS-1:0]   entry_tag;
   logic [COUNT_BITS-1:0] count;
   logic                  done_res;
   logic                  last;

   modport source (output valid, output status, output entry_valid, output entry_key,
                   output entry_tag, output count, output done_res, output last,
                   input ready);
   modport sink   (input valid, input status, input entry_valid, input entry_key,
                   input entry_tag, input count, input done_res, input last,
                   output ready);
endinterface

>>> design/top_n_newest_keeper_core.sv
// Channel   Direction  Handshake            Contents
// req       in         req.valid/req.ready  func, key, tag
// rsp       out        rsp.valid/rsp.ready  status, entry fields, count, done_res, last
// csr       in         csr_we               target_n on csr_wdata
//
// An inserting offer passes S_SCAN, S_DECIDE, S_SHIFT and S_PLACE before S_EMIT loads the output register;
// a duplicate or too-old key passes S_SCAN and S_DECIDE only, and an ignored one goes straight to S_EMIT.
// A drain makes one memory read (S_DR_RD) and one word out (S_DR_OUT) per held entry.
// Reset is synchronous; the list is empty and target_n is eight afterwards.
// A stalled rsp holds its word in the output register; a new request is taken meanwhile,
// and the sequencer waits only when its own word finds that register still full.
`timescale 1ns / 1ps

module top_n_newest_keeper_core
   import tnk_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
   parameter int TAG_BITS    = TAG_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   tnk_req_if.sink               req,
   tnk_rsp_if.source             rsp,
   input  logic                  csr_we,
   input  logic [COUNT_BITS-1:0] csr_wdata
);

   localparam int AW      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CAP_INT = (MAX_ENTRIES > 15) ? 15 : MAX_ENTRIES;
   localparam logic [COUNT_BITS-1:0] CAP = COUNT_BITS'(CAP_INT);

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_PLACE, S_EMIT, S_DR_RD, S_DR_OUT
   } state_type;

   state_type             state_ff;
   logic [COUNT_BITS-1:0] target_ff;
   logic [COUNT_BITS-1:0] fill_ff;
   logic                  ended_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [TAG_BITS-1:0]   tag_ff;
   logic [COUNT_BITS-1:0] idx_ff;
   logic [COUNT_BITS-1:0] lt_ff;
   logic                  dup_ff;
   logic                  pend_ff;
   logic [AW-1:0]         dst_ff;
   logic [COUNT_BITS-1:0] pos_ff;
   logic [COUNT_BITS-1:0] moves_ff;
   logic                  up_ff;
   logic                  grow_ff;
   status_type            status_ff;
   logic [COUNT_BITS-1:0] drain_n_ff;

   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;
   logic                  rsp_evalid_ff;
   logic [KEY_BITS-1:0]   rsp_ekey_ff;
   logic [TAG_BITS-1:0]   rsp_etag_ff;
   logic [COUNT_BITS-1:0] rsp_count_ff;
   logic                  rsp_done_ff;
   logic                  rsp_last_ff;

   logic [KEY_BITS-1:0]   mem_key [MAX_ENTRIES];
   logic [TAG_BITS-1:0]   mem_tag [MAX_ENTRIES];
   logic [KEY_BITS-1:0]   rd_key_ff;
   logic [TAG_BITS-1:0]   rd_tag_ff;

   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [KEY_BITS-1:0]   wr_key;
   logic [TAG_BITS-1:0]   wr_tag;
   logic [COUNT_BITS-1:0] n_eff;
   logic                  out_free;
   logic                  rsp_load;
   logic                  scan_more;
   logic                  drain_last;

   always_comb begin
      if (target_ff == '0) begin
         n_eff = COUNT_BITS'(1);
      end else if (target_ff > CAP) begin
         n_eff = CAP;
      end else begin
         n_eff = target_ff;
      end
   end

   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign rsp_load   = out_free && (state_ff == S_EMIT || state_ff == S_DR_OUT);
   assign scan_more  = (idx_ff < fill_ff);
   assign drain_last = ((idx_ff + COUNT_BITS'(1)) == drain_n_ff);

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_key  = key_ff;
      wr_tag  = tag_ff;
      unique case (state_ff)
         S_SCAN: begin
            if (scan_more) begin
               rd_en   = 1'b1;
               rd_addr = AW'(idx_ff);
            end
         end
         S_SHIFT: begin
            if (moves_ff != '0) begin
               rd_en   = 1'b1;
               rd_addr = AW'(idx_ff);
            end
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = dst_ff;
               wr_key  = rd_key_ff;
               wr_tag  = rd_tag_ff;
            end
         end
         S_PLACE: begin
            wr_en   = 1'b1;
            wr_addr = AW'(pos_ff);
         end
         S_DR_RD: begin
            rd_en   = 1'b1;
            rd_addr = AW'(idx_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_key[wr_addr] <= wr_key;
         mem_tag[wr_addr] <= wr_tag;
      end
      if (rd_en) begin
         rd_key_ff <= mem_key[rd_addr];
         rd_tag_ff <= mem_tag[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         target_ff    <= TARGET_N_RESET;
         fill_ff      <= '0;
         ended_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            target_ff <= csr_wdata;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  key_ff  <= req.key;
                  tag_ff  <= req.tag;
                  idx_ff  <= '0;
                  lt_ff   <= '0;
                  dup_ff  <= 1'b0;
                  pend_ff <= 1'b0;
                  if (req.func == FUNC_DRAIN) begin
                     drain_n_ff <= fill_ff;
                     fill_ff    <= '0;
                     ended_ff   <= 1'b0;
                     if (fill_ff == '0) begin
                        status_ff <= ST_ENTRY;
                        state_ff  <= S_EMIT;
                     end else begin
                        state_ff <= S_DR_RD;
                     end
                  end else if (ended_ff) begin
                     status_ff <= ST_IGNORED;
                     state_ff  <= S_EMIT;
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               if (scan_more) begin
                  idx_ff <= idx_ff + COUNT_BITS'(1);
               end
               pend_ff <= scan_more;
               if (pend_ff) begin
                  if (rd_key_ff < key_ff) begin
                     lt_ff <= lt_ff + COUNT_BITS'(1);
                  end
                  if (rd_key_ff == key_ff) begin
                     dup_ff <= 1'b1;
                  end
               end
               if (!scan_more && !pend_ff) begin
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               priority if (dup_ff) begin
                  status_ff <= ST_DUPLICATE;
                  state_ff  <= S_EMIT;
               end else if (fill_ff < n_eff) begin
                  pos_ff   <= lt_ff;
                  idx_ff   <= fill_ff - COUNT_BITS'(1);
                  moves_ff <= fill_ff - lt_ff;
                  up_ff    <= 1'b0;
                  grow_ff  <= 1'b1;
                  state_ff <= S_SHIFT;
               end else if (lt_ff == '0) begin
                  ended_ff  <= 1'b1;
                  status_ff <= ST_TOO_OLD;
                  state_ff  <= S_EMIT;
               end else begin
                  pos_ff   <= lt_ff - COUNT_BITS'(1);
                  idx_ff   <= COUNT_BITS'(1);
                  moves_ff <= lt_ff - COUNT_BITS'(1);
                  up_ff    <= 1'b1;
                  grow_ff  <= 1'b0;
                  state_ff <= S_SHIFT;
               end
            end
            S_SHIFT: begin
               if (moves_ff != '0) begin
                  moves_ff <= moves_ff - COUNT_BITS'(1);
                  pend_ff  <= 1'b1;
                  if (up_ff) begin
                     idx_ff <= idx_ff + COUNT_BITS'(1);
                     dst_ff <= AW'(idx_ff - COUNT_BITS'(1));
                  end else begin
                     idx_ff <= idx_ff - COUNT_BITS'(1);
                     dst_ff <= AW'(idx_ff + COUNT_BITS'(1));
                  end
               end else begin
                  pend_ff  <= 1'b0;
                  state_ff <= S_PLACE;
               end
            end
            S_PLACE: begin
               fill_ff   <= fill_ff + COUNT_BITS'(grow_ff);
               status_ff <= ST_INSERTED;
               state_ff  <= S_EMIT;
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_status_ff <= status_ff;
                  rsp_evalid_ff <= 1'b0;
                  rsp_ekey_ff   <= '0;
                  rsp_etag_ff   <= '0;
                  rsp_count_ff  <= fill_ff;
                  rsp_done_ff   <= ended_ff;
                  rsp_last_ff   <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            S_DR_RD: begin
               state_ff <= S_DR_OUT;
            end
            S_DR_OUT: begin
               if (out_free) begin
                  rsp_status_ff <= ST_ENTRY;
                  rsp_evalid_ff <= 1'b1;
                  rsp_ekey_ff   <= rd_key_ff;
                  rsp_etag_ff   <= rd_tag_ff;
                  rsp_count_ff  <= '0;
                  rsp_done_ff   <= 1'b0;
                  rsp_last_ff   <= drain_last;
                  idx_ff        <= idx_ff + COUNT_BITS'(1);
                  state_ff      <= drain_last ? S_IDLE : S_DR_RD;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req.ready       = (state_ff == S_IDLE);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.entry_valid = rsp_evalid_ff;
   assign rsp.entry_key   = rsp_ekey_ff;
   assign rsp.entry_tag   = rsp_etag_ff;
   assign rsp.count       = rsp_count_ff;
   assign rsp.done_res    = rsp_done_ff;
   assign rsp.last        = rsp_last_ff;

endmodule

>>> design/tnk_checker.sv
`timescale 1ns / 1ps

module tnk_checker
   import tnk_pkg::*;
#(
   parameter int TAG_BITS = TAG_BITS_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input status_type            rsp_status,
   input logic                  rsp_entry_valid,
   input logic [KEY_BITS-1:0]   rsp_entry_key,
   input logic [TAG_BITS-1:0]   rsp_entry_tag,
   input logic [COUNT_BITS-1:0] rsp_count,
   input logic                  rsp_done_res,
   input logic                  rsp_last
);

   // A stalled word must stay put until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_entry_key) && $stable(rsp_entry_tag) && $stable(rsp_last))
      else $error("rsp word changed while stalled");

   // Drained entries report the state after the list has been cleared.
   a_entry_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_valid |->
         rsp_status == ST_ENTRY && rsp_count == '0 && !rsp_done_res)
      else $error("drained entry with wrong status or state");

   // An offer gives exactly one word with no entry payload.
   a_offer_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_ENTRY |->
         rsp_last && !rsp_entry_valid && rsp_entry_key == '0 && rsp_entry_tag == '0)
      else $error("offer word malformed");

   // Once an old key has ended the scan, the flag must be shown.
   a_ended_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_TOO_OLD || rsp_status == ST_IGNORED) |->
         rsp_done_res)
      else $error("scan end not flagged");

endmodule

bind top_n_newest_keeper_core tnk_checker #(.TAG_BITS(TAG_BITS)) u_tnk_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_status      (rsp.status),
   .rsp_entry_valid (rsp.entry_valid),
   .rsp_entry_key   (rsp.entry_key),
   .rsp_entry_tag   (rsp.entry_tag),
   .rsp_count       (rsp.count),
   .rsp_done_res    (rsp.done_res),
   .rsp_last        (rsp.last)
);
